@@ rtl/way_partitioned_lru_replacer_assert.svh @@
// Assertion macros shared by the replacement-state RTL.
`ifndef WAY_PARTITIONED_LRU_REPLACER_ASSERT_SVH
`define WAY_PARTITIONED_LRU_REPLACER_ASSERT_SVH
`ifndef SYNTHESIS
`define WPLRU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wplru: same-cycle check failed");
`define WPLRU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wplru: next-cycle check failed");
`else
`define WPLRU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WPLRU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/wplru_pkg.sv @@
// Shared types and constants of the way-partitioned LRU replacer.
package wplru_pkg;

   localparam int WAYS_DEF = 16;
   localparam int SETS_DEF = 2048;

   localparam int SET_INDEX_W = 11;
   localparam int WAY_INDEX_W = 4;
   localparam int AGE_W       = 4;
   localparam int PART_W      = 5;

   localparam logic [AGE_W-1:0]  AGE_MAX    = 4'd15;
   localparam logic [PART_W-1:0] PART_RESET = 5'd8;

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_TOUCH = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [WAY_INDEX_W-1:0] victim_way;
      logic                   was_invalid;
      logic                   no_victim;
   } pick_rsp_type;

endpackage

@@ rtl/wplru_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module wplru_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/wplru_pick.sv @@
// Victim selection over one set row: first invalid way, else partition-aware oldest line.
module wplru_pick #(
   parameter int WAYS = wplru_pkg::WAYS_DEF
) (
   input  logic [WAYS-1:0]                        valid,
   input  logic [WAYS-1:0]                        owner,
   input  logic [WAYS-1:0][wplru_pkg::AGE_W-1:0]  age,
   input  logic [wplru_pkg::PART_W-1:0]           partition,
   input  logic                                   core,
   output wplru_pkg::pick_rsp_type                rsp
);
   import wplru_pkg::*;

   localparam int WAY_W  = $clog2(WAYS);
   localparam int LEAVES = 1 << WAY_W;
   localparam int CNT_W  = $clog2(WAYS + 1);
   localparam int CMP_W  = 7;

   logic               inv_found;
   logic [WAY_W-1:0]   inv_idx;
   logic [CNT_W-1:0]   count0;
   logic               target;
   logic [WAY_W:0][LEAVES-1:0]              t_hit;
   logic [WAY_W:0][LEAVES-1:0][WAY_W-1:0]   t_idx;
   logic [WAY_W:0][LEAVES-1:0][AGE_W-1:0]   t_age;
   logic [WAY_W+WAY_INDEX_W-1:0]            way_ext;

   // Scanning downward leaves the lowest-numbered invalid way.
   always_comb begin
      inv_found = 1'b0;
      inv_idx   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid[w]) begin
            inv_found = 1'b1;
            inv_idx   = WAY_W'(w);
         end
      end
   end

   always_comb begin
      count0 = CNT_W'($countones(~owner));
      if (CMP_W'(partition) > CMP_W'(count0)) begin
         target = 1'b1;
      end else if (CMP_W'(partition) < CMP_W'(count0)) begin
         target = 1'b0;
      end else begin
         target = core;
      end
   end

   // Max tree on age; the right (higher-numbered) side wins ties.
   always_comb begin
      t_hit = '0;
      t_idx = '0;
      t_age = '0;
      for (int l = 0; l < LEAVES; l++) begin
         if (l < WAYS) begin
            t_hit[0][l] = (owner[l] == target);
            t_idx[0][l] = WAY_W'(l);
            t_age[0][l] = age[l];
         end
      end
      for (int lv = 0; lv < WAY_W; lv++) begin
         for (int n = 0; n < (LEAVES >> (lv + 1)); n++) begin
            if (t_hit[lv][2*n+1] &&
                (!t_hit[lv][2*n] || (t_age[lv][2*n+1] >= t_age[lv][2*n]))) begin
               t_hit[lv+1][n] = 1'b1;
               t_idx[lv+1][n] = t_idx[lv][2*n+1];
               t_age[lv+1][n] = t_age[lv][2*n+1];
            end else begin
               t_hit[lv+1][n] = t_hit[lv][2*n];
               t_idx[lv+1][n] = t_idx[lv][2*n];
               t_age[lv+1][n] = t_age[lv][2*n];
            end
         end
      end
   end

   always_comb begin
      rsp = '0;
      way_ext = '0;
      if (inv_found) begin
         way_ext          = {{WAY_INDEX_W{1'b0}}, inv_idx};
         rsp.victim_way   = way_ext[WAY_INDEX_W-1:0];
         rsp.was_invalid  = 1'b1;
      end else if (t_hit[WAY_W][0]) begin
         way_ext          = {{WAY_INDEX_W{1'b0}}, t_idx[WAY_W][0]};
         rsp.victim_way   = way_ext[WAY_INDEX_W-1:0];
      end else begin
         rsp.no_victim    = 1'b1;
      end
   end

endmodule

@@ rtl/way_partitioned_lru_replacer.sv @@
// Top level of the way-partitioned LRU replacer: FSM, set-row RAM and touch update.
// A query's result, registered at the end of EVAL, strobes on rsp_valid after the READ and EVAL states.
// A new item is taken only in IDLE, after the last has passed a set-index reduction step,
// a row read, then evaluation and row write-back through the single set-row RAM.
// A touch gives no result. After synchronous reset the block sweeps all SETS rows
// to zero, one row per cycle, with busy high; the partition register part_ff resets to 8.
module way_partitioned_lru_replacer #(
   parameter int WAYS = wplru_pkg::WAYS_DEF,
   parameter int SETS = wplru_pkg::SETS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [wplru_pkg::SET_INDEX_W-1:0]   req_set_index,
   input  logic [wplru_pkg::WAY_INDEX_W-1:0]   req_way_index,
   input  logic                                req_core_id,
   output logic                                rsp_valid,
   output logic [wplru_pkg::WAY_INDEX_W-1:0]   rsp_victim_way,
   output logic                                rsp_was_invalid,
   output logic                                rsp_no_victim,
   input  logic                                csr_we,
   input  logic [wplru_pkg::PART_W-1:0]        csr_wdata
);
   import wplru_pkg::*;
`include "way_partitioned_lru_replacer_assert.svh"

   localparam int WAY_W  = $clog2(WAYS);
   localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_W  = WAYS * (2 + AGE_W);
   localparam int DIV_K  = SET_INDEX_W + $clog2(SETS);
   localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + SETS - 1) / SETS;
   localparam int PROD_W = SET_INDEX_W + DIV_K + 2;
   localparam int REM_W  = SET_INDEX_W + 18;

   state_type state_ff, state_in;

   logic                    cmd_ff, core_ff;
   logic [SET_INDEX_W-1:0]  set_ff, quot_ff;
   logic [WAY_INDEX_W-1:0]  way_ff;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       clr_ff;
   logic [PART_W-1:0]       part_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   pick_rsp_type            rsp_ff;

   logic                    accept;
   logic [PROD_W-1:0]       prod;
   logic [REM_W-1:0]        rem;

   logic                    ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ROW_W-1:0]        ram_wr_data, ram_rd_data;

   logic [WAYS-1:0]               valid_rd, owner_rd, valid_new, owner_new;
   logic [WAYS-1:0][AGE_W-1:0]    age_rd, age_new;
   logic [AGE_W-1:0]              ref_age;
   logic [WAY_W+WAY_INDEX_W-1:0]  way_ext;
   logic [WAY_W-1:0]              way_sel;
   logic                          way_ok;
   logic                          clr_done;
   pick_rsp_type                  pick_rsp;

   assign accept = start && !busy;

   // Set index modulo SETS: exact reciprocal multiply, then a constant multiply-subtract.
   assign prod = PROD_W'(req_set_index) * PROD_W'(DIV_M);
   assign rem  = REM_W'(set_ff) - REM_W'(quot_ff) * REM_W'(SETS);
   assign addr_in  = rem[ADDR_W-1:0];
   assign clr_done = (clr_ff == ADDR_W'(SETS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      ram_rd_en    = (state_ff == ST_READ);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = {age_new, owner_new, valid_new};
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_EVAL: begin
            ram_wr_en    = (cmd_ff == CMD_TOUCH) && way_ok;
            rsp_valid_in = (cmd_ff == CMD_QUERY);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         part_ff      <= PART_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (csr_we) begin
            part_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         set_ff  <= req_set_index;
         way_ff  <= req_way_index;
         core_ff <= req_core_id;
         quot_ff <= prod[DIV_K +: SET_INDEX_W];
      end
      if (state_ff == ST_READ) begin
         addr_ff <= addr_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= pick_rsp;
      end
   end

   wplru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_in),
      .rd_data (ram_rd_data)
   );

   assign valid_rd = ram_rd_data[WAYS-1:0];
   assign owner_rd = ram_rd_data[2*WAYS-1:WAYS];
   assign age_rd   = ram_rd_data[ROW_W-1:2*WAYS];

   assign way_ext = {{WAY_W{1'b0}}, way_ff};
   assign way_sel = way_ext[WAY_W-1:0];
   assign way_ok  = (32'(way_ff) < WAYS);
   assign ref_age = age_rd[way_sel];

   // Touch: the requester's lines younger than the touched way grow one step older.
   always_comb begin
      valid_new = valid_rd;
      owner_new = owner_rd;
      for (int w = 0; w < WAYS; w++) begin
         if ((owner_rd[w] == core_ff) && (age_rd[w] < ref_age) && (age_rd[w] < AGE_MAX)) begin
            age_new[w] = age_rd[w] + AGE_W'(1);
         end else begin
            age_new[w] = age_rd[w];
         end
      end
      age_new[way_sel]   = '0;
      valid_new[way_sel] = 1'b1;
      owner_new[way_sel] = core_ff;
   end

   wplru_pick #(
      .WAYS (WAYS)
   ) u_pick (
      .valid     (valid_rd),
      .owner     (owner_rd),
      .age       (age_rd),
      .partition (part_ff),
      .core      (core_ff),
      .rsp       (pick_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_victim_way  = rsp_ff.victim_way;
   assign rsp_was_invalid = rsp_ff.was_invalid;
   assign rsp_no_victim   = rsp_ff.no_victim;

   `WPLRU_ASSERT_NXT(a_query_strobes, clock, reset, (state_ff == ST_EVAL) && (cmd_ff == CMD_QUERY), rsp_valid)
   `WPLRU_ASSERT_NXT(a_accept_reads, clock, reset, accept, (state_ff == ST_READ) && busy)
   `WPLRU_ASSERT_IMP(a_write_owner, clock, reset, ram_wr_en, (state_ff == ST_CLEAR) || ((state_ff == ST_EVAL) && (cmd_ff == CMD_TOUCH)))
   `WPLRU_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_was_invalid && rsp_no_victim))

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the way-partitioned LRU replacer, with its own shadow of the set state.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wplru_pkg::*;

   localparam int NWAYS       = WAYS_DEF;
   localparam int NSETS       = SETS_DEF;
   localparam int NSLOTS      = NWAYS * NSETS;
   localparam int STALL_LIMIT = 10000;
   localparam int PHASE_ITEMS = 280;
   localparam int NPHASES     = 7;
   localparam int POOL_SIZE   = 8;

   class lru_scoreboard;
      bit                     line_valid [NSLOTS];
      bit                     line_owner [NSLOTS];
      bit [AGE_W-1:0]         line_age [NSLOTS];
      bit [PART_W-1:0]        partition;
      pick_rsp_type           expected_picks [$];
      pick_rsp_type           last_pick;
      int                     faults;
      int                     n_query;
      int                     n_touch;
      int                     n_empty;
      int                     n_full;
      int                     n_none;

      function new();
         partition = PART_RESET;
      endfunction

      function void set_partition(logic [PART_W-1:0] value);
         partition = value;
      endfunction

      // Applies one accepted item to the shadow state; a query queues its pick.
      function void note_item(logic cmd, logic [SET_INDEX_W-1:0] set_idx,
                              logic [WAY_INDEX_W-1:0] way, logic core);
         int             base;
         int             count0;
         int             best;
         bit             found;
         bit             target;
         bit [AGE_W-1:0] ref_age;
         bit [AGE_W-1:0] top;
         pick_rsp_type   want;
         base = (int'(set_idx) % NSETS) * NWAYS;
         if (cmd == CMD_TOUCH) begin
            n_touch++;
            if (int'(way) >= NWAYS) return;
            ref_age = line_age[base + way];
            for (int w = 0; w < NWAYS; w++) begin
               if (line_owner[base + w] == core && line_age[base + w] < ref_age &&
                   line_age[base + w] < AGE_MAX)
                  line_age[base + w]++;
            end
            line_age[base + way]   = '0;
            line_valid[base + way] = 1'b1;
            line_owner[base + way] = core;
            return;
         end
         n_query++;
         want  = '0;
         found = 1'b0;
         for (int w = 0; w < NWAYS && !found; w++) begin
            if (!line_valid[base + w]) begin
               want.victim_way  = WAY_INDEX_W'(w);
               want.was_invalid = 1'b1;
               found            = 1'b1;
            end
         end
         if (found) begin
            n_empty++;
         end else begin
            n_full++;
            count0 = 0;
            for (int w = 0; w < NWAYS; w++)
               if (line_owner[base + w] == 1'b0) count0++;
            if (int'(partition) > count0)
               target = 1'b1;
            else if (int'(partition) < count0)
               target = 1'b0;
            else
               target = core;
            // The highest-numbered way wins among lines of equal age.
            best = NWAYS;
            top  = '0;
            for (int w = 0; w < NWAYS; w++) begin
               if (line_owner[base + w] == target && line_age[base + w] >= top) begin
                  top  = line_age[base + w];
                  best = w;
               end
            end
            if (best >= NWAYS) begin
               want.no_victim = 1'b1;
               n_none++;
            end else begin
               want.victim_way = WAY_INDEX_W'(best);
            end
         end
         last_pick = want;
         expected_picks.push_back(want);
      endfunction

      function void check_pick(logic [WAY_INDEX_W-1:0] way, logic was_invalid,
                               logic no_victim);
         pick_rsp_type want;
         if (expected_picks.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("ERROR: unexpected result way %0d invalid %b none %b",
                        way, was_invalid, no_victim);
            return;
         end
         want = expected_picks.pop_front();
         if (way !== want.victim_way || was_invalid !== want.was_invalid ||
             no_victim !== want.no_victim) begin
            faults++;
            if (faults <= 10)
               $display("ERROR: expected way %0d inv %b none %b, got way %0d inv %b none %b",
                        want.victim_way, want.was_invalid, want.no_victim,
                        way, was_invalid, no_victim);
         end
      endfunction
   endclass

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   start         = 1'b0;
   logic                   req_cmd       = CMD_QUERY;
   logic [SET_INDEX_W-1:0] req_set_index = '0;
   logic [WAY_INDEX_W-1:0] req_way_index = '0;
   logic                   req_core_id   = 1'b0;
   logic                   csr_we        = 1'b0;
   logic [PART_W-1:0]      csr_wdata     = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [WAY_INDEX_W-1:0] rsp_victim_way;
   logic                   rsp_was_invalid;
   logic                   rsp_no_victim;

   lru_scoreboard          sb;
   int                     stall_count   = 0;
   int                     item_count    = 0;
   int                     cfg_writes    = 0;
   bit                     quiet         = 1'b0;
   bit                     final_stretch = 1'b0;

   way_partitioned_lru_replacer #(
      .WAYS(NWAYS),
      .SETS(NSETS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_set_index  (req_set_index),
      .req_way_index  (req_way_index),
      .req_core_id    (req_core_id),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way),
      .rsp_was_invalid(rsp_was_invalid),
      .rsp_no_victim  (rsp_no_victim),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         sb.check_pick(rsp_victim_way, rsp_was_invalid, rsp_no_victim);
   end

   // The watchdog restarts whenever an item or a result moves.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Called at a rising edge; returns at the edge that accepts the item.
   task automatic send_item(logic cmd, logic [SET_INDEX_W-1:0] set_idx,
                            logic [WAY_INDEX_W-1:0] way, logic core);
      req_cmd       <= cmd;
      req_set_index <= set_idx;
      req_way_index <= way;
      req_core_id   <= core;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_item(cmd, set_idx, way, core);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      item_count++;
      if (item_count % 64 == 0) quiet = ($urandom_range(9) < 3);
      if (!quiet && !final_stretch && $urandom_range(3) == 0)
         hold_off($urandom_range(1, 11));
   endtask

   // A touch gives no result, so the task also waits for busy to fall before the write.
   task automatic write_partition(logic [PART_W-1:0] value);
      start <= 1'b0;
      while (sb.expected_picks.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_partition(value);
      cfg_writes++;
   endtask

   initial begin
      int                     plan [NPHASES];
      int                     pool [POOL_SIZE];
      int                     bias [POOL_SIZE];
      int                     sent;
      int                     r;
      int                     slot;
      logic [SET_INDEX_W-1:0] set_idx;
      logic [WAY_INDEX_W-1:0] way;
      logic                   core;

      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      // The block clears every row after reset with busy high.
      while (busy !== 1'b0) @(posedge clock);

      write_partition(PART_RESET);
      send_item(CMD_QUERY, '0, '0, 1'b0);
      send_item(CMD_QUERY, '1, '1, 1'b1);
      send_item(CMD_TOUCH, '1, 4'd9, 1'b1);
      for (int w = 0; w < NWAYS; w++)
         send_item(CMD_TOUCH, 11'd3, WAY_INDEX_W'(w), 1'b0);
      send_item(CMD_QUERY, 11'd3, '0, 1'b1);
      // With the share above every count, a set held only by core 0 has no victim.
      write_partition(5'd31);
      send_item(CMD_QUERY, 11'd3, '0, 1'b0);
      write_partition(5'd16);
      send_item(CMD_QUERY, 11'd3, '0, 1'b1);
      send_item(CMD_QUERY, 11'd3, '0, 1'b0);
      send_item(CMD_TOUCH, 11'd3, 4'd15, 1'b1);
      send_item(CMD_QUERY, 11'd3, '0, 1'b0);
      send_item(CMD_TOUCH, 11'd3, 4'd0, 1'b1);

      plan = '{0, 31, $urandom_range(1, 15), 16, $urandom_range(17, 30), 8,
               $urandom_range(0, 31)};
      pool[0] = 0;
      pool[1] = NSETS - 1;
      pool[2] = 3;
      for (int i = 3; i < POOL_SIZE; i++) pool[i] = $urandom_range(NSETS - 1);

      for (int p = 0; p < NPHASES; p++) begin
         write_partition(PART_W'(plan[p]));
         final_stretch = (p == NPHASES - 1);
         for (int i = 0; i < 2; i++) pool[$urandom_range(3, POOL_SIZE - 1)] =
            $urandom_range(NSETS - 1);
         // Each set leans to core 0, to core 1, or to neither for this phase.
         for (int i = 0; i < POOL_SIZE; i++) bias[i] = $urandom_range(2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r       = $urandom_range(99);
            slot    = $urandom_range(POOL_SIZE - 1);
            set_idx = SET_INDEX_W'(pool[slot]);
            core    = (bias[slot] == 2) ? 1'($urandom_range(1)) : 1'(bias[slot]);
            way     = WAY_INDEX_W'($urandom_range(NWAYS - 1));
            if (r < 70) begin
               // A miss: ask for a victim, then fill the way that came back.
               send_item(CMD_QUERY, set_idx, way, core);
               maybe_idle();
               if (!sb.last_pick.no_victim) way = sb.last_pick.victim_way;
               send_item(CMD_TOUCH, set_idx, way, core);
               sent += 2;
            end else if (r < 88) begin
               send_item(CMD_TOUCH, set_idx, way, core);
               sent++;
            end else if (r < 94) begin
               send_item(CMD_QUERY, set_idx, way, ~core);
               sent++;
            end else begin
               send_item(1'($urandom_range(1)), SET_INDEX_W'($urandom_range(NSETS - 1)),
                         way, 1'($urandom_range(1)));
               sent++;
            end
            maybe_idle();
         end
      end

      start <= 1'b0;
      while (sb.expected_picks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d queries and %0d touches under %0d partition settings.",
               sb.n_query, sb.n_touch, cfg_writes);
      $display("Picks: %0d empty ways, %0d from full sets, %0d with no line of the chosen core.",
               sb.n_empty, sb.n_full, sb.n_none);
      if (sb.faults == 0 && sb.expected_picks.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.faults);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
